// File: src/paren_pair_extractor_defines.svh
// ----------------------------------------------------------------------------
// paren pair extractor assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef PAREN_PAIR_EXTRACTOR_DEFINES_SVH
`define PAREN_PAIR_EXTRACTOR_DEFINES_SVH

// same-cycle implication, off while in reset
`define PPE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("paren pair extractor check failed");

// next-cycle implication, off while in reset
`define PPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("paren pair extractor check failed");

// next-cycle implication that also covers reset cycles
`define PPE_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("paren pair extractor check failed");

`endif

// File: src/ppe_pkg.sv
// ----------------------------------------------------------------------------
// ppe_pkg
// types and constants shared by the paren pair extractor
// ----------------------------------------------------------------------------
package ppe_pkg;

    localparam int POS_W       = 12;
    localparam int CHAR_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_AND    = 8'h26;
    localparam logic [CHAR_W-1:0] CH_OR     = 8'h7c;

    typedef enum logic [1:0] {
        KIND_PAIR  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CMD_PUSH,
        CMD_OP,
        CMD_POP,
        CMD_DONE,
        CMD_ERR
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code          code;
        logic [POS_W-1:0]   pos;
    } t_cmd;

endpackage

// File: src/ppe_stream_if.sv
// ----------------------------------------------------------------------------
// ppe stream interfaces
// valid/ready channels for characters in and results out
// ----------------------------------------------------------------------------
interface ppe_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface ppe_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] open_pos;
    logic        op_valid;
    logic [11:0] op_pos;
    logic [11:0] close_pos;

    modport source (output valid, output kind, output open_pos, output op_valid,
                    output op_pos, output close_pos, input ready);
    modport sink   (input valid, input kind, input open_pos, input op_valid,
                    input op_pos, input close_pos, output ready);
endinterface

// File: src/ppe_front.sv
// ----------------------------------------------------------------------------
// ppe_front
// accepts characters, tracks position and stack depth, issues stack commands
// ----------------------------------------------------------------------------
module ppe_front import ppe_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int MAX_LEN     = 4096,
    parameter int IW          = $clog2(STACK_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ppe_char_if.sink      i_char,
    input  logic          i_q_full,
    output logic          o_cmd_valid,
    output t_cmd          o_cmd,
    output logic [IW-1:0] o_idx
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int PW = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(STACK_DEPTH);
    localparam logic [PW-1:0] MAX_POS   = PW'(MAX_LEN);

    logic [PW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_count, n_count;
    logic          r_op_seen, n_op_seen;
    logic          r_discard, n_discard;
    logic [CW-1:0] count_m1;
    logic          accept;

    assign i_char.ready = !i_q_full;
    assign accept       = i_char.valid && i_char.ready;
    assign count_m1     = r_count - CW'(1);

    always_comb begin
        n_pos       = r_pos;
        n_count     = r_count;
        n_op_seen   = r_op_seen;
        n_discard   = r_discard;
        o_cmd_valid = 1'b0;
        o_cmd.code  = CMD_DONE;
        o_cmd.pos   = POS_W'(r_pos);
        o_idx       = count_m1[IW-1:0];
        if (accept) begin
            if (i_char.char_code == CH_NUL) begin
                n_pos     = '0;
                n_count   = '0;
                n_op_seen = 1'b0;
                n_discard = 1'b0;
                if (!r_discard) begin
                    o_cmd_valid = 1'b1;
                    o_cmd.code  = CMD_DONE;
                end
            end else if (!r_discard) begin
                if (r_pos >= MAX_POS) begin
                    o_cmd_valid = 1'b1;
                    o_cmd.code  = CMD_ERR;
                    n_discard   = 1'b1;
                end else begin
                    n_pos = r_pos + PW'(1);
                    case (i_char.char_code)
                        CH_LPAREN: begin
                            o_cmd_valid = 1'b1;
                            if (r_count >= DEPTH_CNT) begin
                                o_cmd.code = CMD_ERR;
                                n_discard  = 1'b1;
                            end else begin
                                o_cmd.code = CMD_PUSH;
                                o_idx      = r_count[IW-1:0];
                                n_count    = r_count + CW'(1);
                                n_op_seen  = 1'b0;
                            end
                        end
                        CH_AND, CH_OR: begin
                            o_cmd_valid = 1'b1;
                            if (r_op_seen || r_count == '0) begin
                                o_cmd.code = CMD_ERR;
                                n_discard  = 1'b1;
                            end else begin
                                o_cmd.code = CMD_OP;
                                n_op_seen  = 1'b1;
                            end
                        end
                        CH_RPAREN: begin
                            o_cmd_valid = 1'b1;
                            if (r_count == '0) begin
                                o_cmd.code = CMD_ERR;
                                n_discard  = 1'b1;
                            end else begin
                                o_cmd.code = CMD_POP;
                                n_count    = count_m1;
                                n_op_seen  = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_count   <= '0;
            r_op_seen <= 1'b0;
            r_discard <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_op_seen <= n_op_seen;
            r_discard <= n_discard;
        end
    end

endmodule

// File: src/ppe_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ppe_cmd_fifo
// short command queue between the front and back ends
// ----------------------------------------------------------------------------
module ppe_cmd_fifo import ppe_pkg::*; #(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_AW:0]   r_fill;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_fill == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QUEUE_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + (QUEUE_AW + 1)'(1);
                2'b01:   r_fill <= r_fill - (QUEUE_AW + 1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// File: src/ppe_back.sv
// ----------------------------------------------------------------------------
// ppe_back
// runs stack commands on the entry memory and holds the result register
// ----------------------------------------------------------------------------
module ppe_back import ppe_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int IW          = $clog2(STACK_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  t_cmd          i_q_cmd,
    input  logic [IW-1:0] i_q_idx,
    output logic          o_q_pop,
    ppe_result_if.source  o_result
);

    logic [POS_W-1:0] r_open_mem [STACK_DEPTH];
    logic [POS_W:0]   r_op_mem   [STACK_DEPTH];

    logic             r_out_valid;
    t_kind            r_out_kind;
    logic [POS_W-1:0] r_out_close;
    logic [POS_W-1:0] r_rd_open;
    logic [POS_W:0]   r_rd_op;
    logic             advance;
    logic             has_result;
    t_kind            n_kind;

    assign advance = !r_out_valid || o_result.ready;
    assign o_q_pop = i_q_valid && advance;

    always_comb begin
        has_result = 1'b0;
        n_kind     = KIND_PAIR;
        case (i_q_cmd.code)
            CMD_POP: begin
                has_result = 1'b1;
                n_kind     = KIND_PAIR;
            end
            CMD_DONE: begin
                has_result = 1'b1;
                n_kind     = KIND_DONE;
            end
            CMD_ERR: begin
                has_result = 1'b1;
                n_kind     = KIND_ERROR;
            end
            default: begin
                has_result = 1'b0;
            end
        endcase
    end

    // stack entry memory
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            case (i_q_cmd.code)
                CMD_PUSH: begin
                    r_open_mem[i_q_idx] <= i_q_cmd.pos;
                    r_op_mem[i_q_idx]   <= '0;
                end
                CMD_OP: begin
                    r_op_mem[i_q_idx] <= {1'b1, i_q_cmd.pos};
                end
                CMD_POP: begin
                    r_rd_open <= r_open_mem[i_q_idx];
                    r_rd_op   <= r_op_mem[i_q_idx];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && has_result) begin
            r_out_kind  <= n_kind;
            r_out_close <= i_q_cmd.pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= o_q_pop && has_result;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.kind      = r_out_kind;
    assign o_result.open_pos  = (r_out_kind == KIND_PAIR) ? r_rd_open : '0;
    assign o_result.op_valid  = (r_out_kind == KIND_PAIR) ? r_rd_op[POS_W] : 1'b0;
    assign o_result.op_pos    = (r_out_kind == KIND_PAIR) ? r_rd_op[POS_W-1:0] : '0;
    assign o_result.close_pos = (r_out_kind == KIND_PAIR) ? r_out_close : '0;

endmodule

// File: src/paren_pair_extractor.sv
// an accepted character's command is queued, then its result is registered
// throughput is one character per cycle unless the queue is full, set by the
// front classifier and one stack memory access per cycle in the back end
// reset is synchronous, active low: counters, queue and result valid clear at once
// stack entries are not cleared; only entries below the current depth are read
// ----------------------------------------------------------------------------
// paren_pair_extractor
// matches parentheses in a character stream and reports pair positions
// ----------------------------------------------------------------------------
module paren_pair_extractor import ppe_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int MAX_LEN     = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ppe_char_if.sink     i_char,
    ppe_result_if.source o_result
);

    localparam int IW = $clog2(STACK_DEPTH);
    localparam int QW = IW + $bits(t_cmd);

    logic          cmd_valid;
    t_cmd          cmd;
    logic [IW-1:0] cmd_idx;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_data;
    t_cmd          q_cmd;
    logic [IW-1:0] q_idx;

    ppe_front #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_LEN     (MAX_LEN),
        .IW          (IW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (i_char),
        .i_q_full    (q_full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .o_idx       (cmd_idx)
    );

    ppe_cmd_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_data  ({cmd_idx, cmd}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_cmd = q_data[$bits(t_cmd)-1:0];
    assign q_idx = q_data[QW-1:$bits(t_cmd)];

    ppe_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .IW          (IW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .i_q_idx   (q_idx),
        .o_q_pop   (q_pop),
        .o_result  (o_result)
    );

endmodule

// File: src/ppe_checker.sv
// ----------------------------------------------------------------------------
// ppe_checker
// port-level checks on the result channel of the paren pair extractor
// ----------------------------------------------------------------------------
`include "paren_pair_extractor_defines.svh"

module ppe_checker import ppe_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_kind,
    input logic [11:0] i_open_pos,
    input logic        i_op_valid,
    input logic [11:0] i_op_pos,
    input logic [11:0] i_close_pos
);

    `PPE_ASSERT_IMPL(a_kind_legal, i_clk, i_rst_n, i_valid, (i_kind == KIND_PAIR || i_kind == KIND_DONE || i_kind == KIND_ERROR))
    `PPE_ASSERT_IMPL(a_status_zero, i_clk, i_rst_n, i_valid && i_kind != KIND_PAIR, (i_open_pos == '0 && !i_op_valid && i_op_pos == '0 && i_close_pos == '0))
    `PPE_ASSERT_IMPL(a_no_op_pos, i_clk, i_rst_n, i_valid && !i_op_valid, i_op_pos == '0)
    `PPE_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable({i_kind, i_open_pos, i_op_valid, i_op_pos, i_close_pos}))
    `PPE_ASSERT_ALWAYS_NEXT(a_reset_idle, i_clk, !i_rst_n, !i_valid)

endmodule

bind paren_pair_extractor ppe_checker u_ppe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_result.valid),
    .i_ready     (o_result.ready),
    .i_kind      (o_result.kind),
    .i_open_pos  (o_result.open_pos),
    .i_op_valid  (o_result.op_valid),
    .i_op_pos    (o_result.op_pos),
    .i_close_pos (o_result.close_pos)
);

// File: test/paren_pair_extractor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// paren_pair_extractor_tb
// drives character strings through the extractor and checks every result beat
// against table rows or a scanner tracking the open stack, positions and error
// state; covers error cases, deep nesting, full-length strings and back-pressure
// ----------------------------------------------------------------------------
module paren_pair_extractor_tb;
    import ppe_pkg::*;

    localparam int STACK_SLOTS  = 16;
    localparam int MAX_CHARS    = 4096;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_FROM    = 950;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 8;

    typedef struct packed {
        t_kind            kind;
        logic [POS_W-1:0] open_pos;
        logic             op_valid;
        logic [POS_W-1:0] op_pos;
        logic [POS_W-1:0] close_pos;
    } t_scan_out;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        bit                given;
        t_scan_out         want;
    } t_step_row;

    localparam t_scan_out PREDICTED = '0;
    localparam t_scan_out DONE_OUT  = '{KIND_DONE, 12'd0, 1'b0, 12'd0, 12'd0};
    localparam t_scan_out ERROR_OUT = '{KIND_ERROR, 12'd0, 1'b0, 12'd0, 12'd0};

    localparam t_step_row OPENING_STEPS [0:22] = '{
        '{CH_NUL,    1'b1, DONE_OUT},
        '{CH_RPAREN, 1'b1, ERROR_OUT},
        '{CH_LPAREN, 1'b0, PREDICTED},
        '{CH_NUL,    1'b0, PREDICTED},
        '{CH_AND,    1'b1, ERROR_OUT},
        '{CH_NUL,    1'b0, PREDICTED},
        '{CH_LPAREN, 1'b0, PREDICTED},
        '{CH_OR,     1'b0, PREDICTED},
        '{CH_AND,    1'b1, ERROR_OUT},
        '{CH_NUL,    1'b0, PREDICTED},
        '{CH_LPAREN, 1'b0, PREDICTED},
        '{8'hff,     1'b0, PREDICTED},
        '{CH_AND,    1'b0, PREDICTED},
        '{CH_RPAREN, 1'b1, '{KIND_PAIR, 12'd0, 1'b1, 12'd2, 12'd3}},
        '{CH_LPAREN, 1'b0, PREDICTED},
        '{CH_OR,     1'b0, PREDICTED},
        '{CH_LPAREN, 1'b0, PREDICTED},
        '{CH_RPAREN, 1'b1, '{KIND_PAIR, 12'd6, 1'b0, 12'd0, 12'd7}},
        '{CH_AND,    1'b0, PREDICTED},
        '{CH_RPAREN, 1'b1, '{KIND_PAIR, 12'd4, 1'b1, 12'd8, 12'd9}},
        '{CH_LPAREN, 1'b0, PREDICTED},
        '{8'h01,     1'b0, PREDICTED},
        '{CH_NUL,    1'b1, DONE_OUT}
    };

    logic i_clk;
    logic i_rst_n;

    ppe_char_if   chars ();
    ppe_result_if results ();

    paren_pair_extractor #(
        .STACK_DEPTH(STACK_SLOTS),
        .MAX_LEN    (MAX_CHARS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (chars),
        .o_result(results)
    );

    // scanner state
    logic [POS_W-1:0] nest_open   [STACK_SLOTS];
    logic             nest_has_op [STACK_SLOTS];
    logic [POS_W-1:0] nest_op_at  [STACK_SLOTS];
    int               nest_count;
    int               scan_pos;
    bit               op_pending;
    bit               skipping;

    t_scan_out         expected_out [$];
    logic [CHAR_W-1:0] text_q [$];
    int                mismatch_count;
    int                live_items;
    int                cycle_count;
    bit                idle_on;
    bit                calm;
    bit                hold_req;

    function automatic bit scan_char(input logic [CHAR_W-1:0] c, output t_scan_out r);
        int here;
        bit failed;
        r = '0;
        if (c == CH_NUL) begin
            failed     = skipping;
            nest_count = 0;
            scan_pos   = 0;
            op_pending = 1'b0;
            skipping   = 1'b0;
            if (failed)
                return 1'b0;
            r.kind = KIND_DONE;
            return 1'b1;
        end
        if (skipping)
            return 1'b0;
        if (scan_pos >= MAX_CHARS) begin
            skipping = 1'b1;
            r.kind   = KIND_ERROR;
            return 1'b1;
        end
        here = scan_pos;
        scan_pos++;
        if (c == CH_LPAREN) begin
            if (nest_count >= STACK_SLOTS) begin
                skipping = 1'b1;
                r.kind   = KIND_ERROR;
                return 1'b1;
            end
            nest_open[nest_count]   = here[POS_W-1:0];
            nest_has_op[nest_count] = 1'b0;
            nest_op_at[nest_count]  = '0;
            nest_count++;
            op_pending = 1'b0;
            return 1'b0;
        end
        if (c == CH_AND || c == CH_OR) begin
            if (op_pending || nest_count == 0) begin
                skipping = 1'b1;
                r.kind   = KIND_ERROR;
                return 1'b1;
            end
            nest_has_op[nest_count-1] = 1'b1;
            nest_op_at[nest_count-1]  = here[POS_W-1:0];
            op_pending = 1'b1;
            return 1'b0;
        end
        if (c == CH_RPAREN) begin
            if (nest_count == 0) begin
                skipping = 1'b1;
                r.kind   = KIND_ERROR;
                return 1'b1;
            end
            nest_count--;
            op_pending  = 1'b0;
            r.kind      = KIND_PAIR;
            r.open_pos  = nest_open[nest_count];
            r.op_valid  = nest_has_op[nest_count];
            r.op_pos    = nest_has_op[nest_count] ? nest_op_at[nest_count] : '0;
            r.close_pos = here[POS_W-1:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [CHAR_W-1:0] plain_char();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(1, 255));
        while (c == CH_LPAREN || c == CH_RPAREN || c == CH_AND || c == CH_OR);
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_op();
        return $urandom_range(0, 1) ? CH_AND : CH_OR;
    endfunction

    function automatic logic [CHAR_W-1:0] junk_char();
        case ($urandom_range(0, 4))
            0:       return CH_RPAREN;
            1:       return CH_LPAREN;
            2:       return CH_AND;
            3:       return CH_OR;
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    // expression with at most one operator between parentheses, balanced if close_all
    task automatic add_expr(input int max_nest, input int len, input bit close_all);
        int nest;
        bit op_open;
        int r;
        nest    = 0;
        op_open = 1'b0;
        repeat (len) begin
            r = $urandom_range(0, 7);
            if (r < 2 && nest < max_nest) begin
                text_q.push_back(CH_LPAREN);
                nest++;
                op_open = 1'b0;
            end else if (r < 4 && nest > 0) begin
                text_q.push_back(CH_RPAREN);
                nest--;
                op_open = 1'b0;
            end else if (r == 4 && nest > 0 && !op_open) begin
                text_q.push_back(pick_op());
                op_open = 1'b1;
            end else begin
                text_q.push_back(plain_char());
            end
        end
        if (close_all) begin
            while (nest > 0) begin
                text_q.push_back(CH_RPAREN);
                nest--;
            end
        end
    endtask

    // fills the stack, optionally one open too many
    task automatic add_deep(input bit spill);
        repeat (STACK_SLOTS) begin
            text_q.push_back(CH_LPAREN);
            if ($urandom_range(0, 1))
                text_q.push_back(pick_op());
            if ($urandom_range(0, 2) == 0)
                text_q.push_back(plain_char());
        end
        if (spill)
            text_q.push_back(CH_LPAREN);
        repeat ($urandom_range(0, STACK_SLOTS))
            text_q.push_back(CH_RPAREN);
    endtask

    task automatic send_byte(input logic [CHAR_W-1:0] c, input bit given, input t_scan_out want);
        t_scan_out r;
        bit        has;
        if (!calm && idle_on && $urandom_range(0, 5) == 0) begin
            chars.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        if (!skipping)
            live_items++;
        chars.valid     <= 1'b1;
        chars.char_code <= c;
        @(posedge i_clk);
        while (!chars.ready) @(posedge i_clk);
        has = scan_char(c, r);
        if (given)
            expected_out.push_back(want);
        else if (has)
            expected_out.push_back(r);
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_byte(text_q[i], 1'b0, PREDICTED);
        text_q.delete();
    endtask

    task automatic drain();
        chars.valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic take_result();
        t_scan_out got;
        t_scan_out want;
        got = '{t_kind'(results.kind), results.open_pos, results.op_valid,
                results.op_pos, results.close_pos};
        if (expected_out.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result beat: kind=%0d open=%0d op_valid=%0d op=%0d close=%0d",
                         got.kind, got.open_pos, got.op_valid, got.op_pos, got.close_pos);
            return;
        end
        want = expected_out.pop_front();
        if (got.kind !== want.kind || got.open_pos !== want.open_pos ||
            got.op_valid !== want.op_valid || got.op_pos !== want.op_pos ||
            got.close_pos !== want.close_pos) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display({"result mismatch: expected kind=%0d open=%0d op_valid=%0d op=%0d ",
                          "close=%0d, got kind=%0d open=%0d op_valid=%0d op=%0d close=%0d"},
                         want.kind, want.open_pos, want.op_valid, want.op_pos, want.close_pos,
                         got.kind, got.open_pos, got.op_valid, got.op_pos, got.close_pos);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && results.valid && results.ready)
            take_result();
    end

    // result side back-pressure
    initial begin
        int hold_count;
        results.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                results.ready <= 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    hold_count++;
                end
                results.ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                results.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                results.ready <= 1'b1;
            end else begin
                results.ready <= 1'b1;
            end
        end
    end

    initial begin
        int variant;
        int spot;
        i_rst_n         <= 1'b0;
        chars.valid     <= 1'b0;
        chars.char_code <= '0;
        mismatch_count  = 0;
        live_items      = 0;
        idle_on         = 1'b1;
        calm            = 1'b0;
        hold_req        = 1'b0;
        nest_count      = 0;
        scan_pos        = 0;
        op_pending      = 1'b0;
        skipping        = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (OPENING_STEPS[i])
            send_byte(OPENING_STEPS[i].ch, OPENING_STEPS[i].given, OPENING_STEPS[i].want);
        drain();

        // long result stall while pairs keep coming
        hold_req = 1'b1;
        repeat (12) begin
            text_q.push_back(CH_LPAREN);
            text_q.push_back(CH_RPAREN);
        end
        text_q.push_back(CH_NUL);
        send_text();
        drain();

        // full-length string, last pair ends at the top position
        add_expr(STACK_SLOTS, 4000, 1'b1);
        while (text_q.size() < MAX_CHARS - 3)
            text_q.push_back(plain_char());
        text_q.push_back(CH_LPAREN);
        text_q.push_back(CH_AND);
        text_q.push_back(CH_RPAREN);
        text_q.push_back(CH_NUL);
        send_text();

        // one character past the position limit
        add_expr(STACK_SLOTS, 4000, 1'b1);
        while (text_q.size() < MAX_CHARS)
            text_q.push_back(plain_char());
        text_q.push_back(CH_LPAREN);
        text_q.push_back(plain_char());
        text_q.push_back(CH_NUL);
        send_text();
        drain();

        live_items = 0;
        while (live_items < RANDOM_ITEMS) begin
            calm    = (live_items >= CALM_FROM);
            idle_on = ($urandom_range(0, 3) != 0);
            variant = $urandom_range(0, 9);
            if (variant <= 5) begin
                add_expr($urandom_range(1, STACK_SLOTS), $urandom_range(1, 30),
                         $urandom_range(0, 4) != 0);
            end else if (variant == 6) begin
                add_deep($urandom_range(0, 1));
            end else if (variant <= 8) begin
                add_expr($urandom_range(1, STACK_SLOTS), $urandom_range(1, 30), 1'b1);
                spot = $urandom_range(0, text_q.size());
                text_q.insert(spot, junk_char());
            end else begin
                repeat ($urandom_range(1, 20))
                    text_q.push_back($urandom_range(0, 1) ? junk_char()
                                                          : CHAR_W'($urandom_range(0, 255)));
            end
            text_q.push_back(CH_NUL);
            send_text();
            if (!calm && $urandom_range(0, 24) == 0)
                drain();
        end
        drain();

        if (mismatch_count == 0 && expected_out.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
